// File: hdl/mlex_pkg.sv
// mlex_pkg: shared widths, operation codes and memory sizing for the execute unit.
// No dependencies; compile first.
package mlex_pkg;

  localparam int unsigned XLEN       = 32;
  localparam int unsigned FUNC_W     = 6;
  localparam int unsigned REG_AW     = 5;
  localparam int unsigned IMM_W      = 26;
  localparam int unsigned REG_DEPTH  = 32;
  localparam int unsigned DATA_WORDS = 256;
  localparam int unsigned DM_AW      = $clog2(DATA_WORDS);
  localparam int unsigned APB_AW     = 3;

  localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
  localparam logic [REG_AW-1:0] REG_SP   = 5'd29;
  localparam logic [REG_AW-1:0] REG_RA   = 5'd31;

  localparam logic CFG_START_PC = 1'b0;
  localparam logic CFG_SP_INIT  = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    F_ADD   = 6'd0,  F_ADDU  = 6'd1,  F_SUB   = 6'd2,  F_AND   = 6'd3,
    F_OR    = 6'd4,  F_XOR   = 6'd5,  F_NOR   = 6'd6,  F_NAND  = 6'd7,
    F_SLT   = 6'd8,  F_SLL   = 6'd9,  F_SRL   = 6'd10, F_SRA   = 6'd11,
    F_JR    = 6'd12, F_ADDI  = 6'd13, F_ADDIU = 6'd14, F_LW    = 6'd15,
    F_LH    = 6'd16, F_LHU   = 6'd17, F_LB    = 6'd18, F_LBU   = 6'd19,
    F_SW    = 6'd20, F_SH    = 6'd21, F_SB    = 6'd22, F_LUI   = 6'd23,
    F_ANDI  = 6'd24, F_ORI   = 6'd25, F_NORI  = 6'd26, F_SLTI  = 6'd27,
    F_BEQ   = 6'd28, F_BNE   = 6'd29, F_BGTZ  = 6'd30, F_J     = 6'd31,
    F_JAL   = 6'd32, F_HALT  = 6'd33
  } func_e;

  // memory access kinds carried from address stage to memory stage
  typedef enum logic [2:0] {
    M_NONE = 3'd0, M_LW = 3'd1, M_LH = 3'd2, M_LHU = 3'd3,
    M_LB   = 3'd4, M_LBU = 3'd5, M_SW = 3'd6, M_SHB = 3'd7
  } mem_e;

endpackage

// File: hdl/mlex_ifs.sv
// mlex_ifs: valid/ready channel interfaces for instruction requests and results.
// Depends on mlex_pkg.
interface mlex_req_if;
  logic                          valid;
  logic                          ready;
  logic [mlex_pkg::FUNC_W-1:0]   func;
  logic [mlex_pkg::REG_AW-1:0]   src_index;
  logic [mlex_pkg::REG_AW-1:0]   tgt_index;
  logic [mlex_pkg::REG_AW-1:0]   dst_index;
  logic [mlex_pkg::IMM_W-1:0]    immediate;

  modport source (output valid, func, src_index, tgt_index, dst_index, immediate,
                  input ready);
  modport sink   (input valid, func, src_index, tgt_index, dst_index, immediate,
                  output ready);
endinterface

interface mlex_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          wrote_register;
  logic [mlex_pkg::REG_AW-1:0]   written_index;
  logic [mlex_pkg::XLEN-1:0]     written_value;
  logic [mlex_pkg::XLEN-1:0]     next_pc;
  logic                          halted;

  modport source (output valid, wrote_register, written_index, written_value, next_pc,
                  halted, input ready);
  modport sink   (input valid, wrote_register, written_index, written_value, next_pc,
                  halted, output ready);
endinterface

// File: hdl/mips_like_execute_unit.sv
// mips_like_execute_unit: three-stage execute pipeline around a register-file RAM
// and a data-memory RAM. Depends on mlex_pkg and mlex_ifs.
//
//  channel | dir | handshake             | content
//  req     | in  | valid/ready           | func, src/tgt/dst index, immediate
//  rsp     | out | valid/ready           | register write, next pc, halted
//  apb     | in  | psel/penable, pready=1| start_pc (0x0), stack_pointer_init (0x4)
//
// One request per cycle sustained unless a result is held waiting on rsp.
// Stage 0 reads the register RAM, stage 1 computes and reads the data RAM, stage 2
// merges loads/stores and writes back; results bypass into stage 1 and stage 2.
// The whole pipeline holds while a result waits on rsp; req.ready follows that.
// Reset clears pc, halt and the valid bits of both RAMs at once, no clearing pass.
module mips_like_execute_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mlex_req_if.sink                      req,
  mlex_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mlex_pkg::APB_AW-1:0]   paddr,
  input  logic [mlex_pkg::XLEN-1:0]     pwdata,
  output logic [mlex_pkg::XLEN-1:0]     prdata,
  output logic                          pready
);
  import mlex_pkg::*;

  // configuration
  logic [XLEN-1:0] cfg_pc_q, cfg_sp_q;
  logic            cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == CFG_SP_INIT) ? cfg_sp_q : cfg_pc_q;

  logic adv;
  logic o_v_q;
  assign adv       = !o_v_q || rsp.ready;
  assign req.ready = adv;

  // ---------------- register file RAM ----------------
  logic [XLEN-1:0]      rf_mem [REG_DEPTH];
  logic [REG_DEPTH-1:0] rf_vld_q;
  logic [XLEN-1:0]      rs_ram_q, rt_ram_q;
  logic                 rs_vld_q, rt_vld_q;
  logic                 rf_we;
  logic [REG_AW-1:0]    rf_wa;
  logic [XLEN-1:0]      rf_wd;

  // ---------------- data memory RAM ----------------
  logic [XLEN-1:0]       dm_mem [DATA_WORDS];
  logic [DATA_WORDS-1:0] dm_vld_q;
  logic [XLEN-1:0]       dm_rd_q;
  logic                  dm_rvld_q;
  logic                  dm_we;
  logic [DM_AW-1:0]      dm_wa;
  logic [XLEN-1:0]       dm_wd;

  // ---------------- stage 1 ----------------
  logic              s1_v_q;
  logic [FUNC_W-1:0] s1_func_q;
  logic [REG_AW-1:0] s1_rs_i_q, s1_rt_i_q, s1_rd_i_q;
  logic [IMM_W-1:0]  s1_imm_q;
  logic [XLEN-1:0]   pc_q;
  logic              halt_q;

  // ---------------- stage 2 ----------------
  logic              s2_v_q, s2_wr_q, s2_halt_q;
  logic [REG_AW-1:0] s2_widx_q;
  logic [XLEN-1:0]   s2_val_q, s2_rt_q, s2_npc_q;
  mem_e              s2_mem_q;
  logic              s2_byte_q;
  logic [1:0]        s2_al_q;
  logic [DM_AW-1:0]  s2_wi_q;
  logic [XLEN-1:0]   s2_wval;

  // writes made at the previous advance edge, for reads issued at that edge
  logic              wb_v_q, mw_v_q;
  logic [REG_AW-1:0] wb_idx_q;
  logic [XLEN-1:0]   wb_val_q, mw_data_q;
  logic [DM_AW-1:0]  mw_idx_q;

  function automatic logic [XLEN-1:0] fwd(
    input logic [REG_AW-1:0] idx,
    input logic [XLEN-1:0]   ram,
    input logic              vld,
    input logic              s2_hit,
    input logic [XLEN-1:0]   s2_val,
    input logic              wb_hit,
    input logic [XLEN-1:0]   wb_val
  );
    logic [XLEN-1:0] r;
    if (idx == REG_ZERO)  r = '0;
    else if (s2_hit)      r = s2_val;
    else if (wb_hit)      r = wb_val;
    else if (vld)         r = ram;
    else                  r = '0;
    return r;
  endfunction

  logic [XLEN-1:0] rs, rt;
  assign rs = fwd(s1_rs_i_q, rs_ram_q, rs_vld_q,
                  s2_v_q && s2_wr_q && (s2_widx_q == s1_rs_i_q), s2_wval,
                  wb_v_q && (wb_idx_q == s1_rs_i_q), wb_val_q);
  assign rt = fwd(s1_rt_i_q, rt_ram_q, rt_vld_q,
                  s2_v_q && s2_wr_q && (s2_widx_q == s1_rt_i_q), s2_wval,
                  wb_v_q && (wb_idx_q == s1_rt_i_q), wb_val_q);

  // register RAM: read at accept, write from stage 2 or configuration
  always_comb begin
    if (cfg_we && paddr[2] == CFG_SP_INIT) begin
      rf_we = 1'b1;
      rf_wa = REG_SP;
      rf_wd = pwdata;
    end else begin
      rf_we = adv && s2_v_q && s2_wr_q;
      rf_wa = s2_widx_q;
      rf_wd = s2_wval;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
    if (adv) begin
      rs_ram_q <= rf_mem[req.src_index];
      rt_ram_q <= rf_mem[req.tgt_index];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
      rs_vld_q <= 1'b0;
      rt_vld_q <= 1'b0;
    end else begin
      if (rf_we) rf_vld_q[rf_wa] <= 1'b1;
      if (adv) begin
        rs_vld_q <= rf_vld_q[req.src_index];
        rt_vld_q <= rf_vld_q[req.tgt_index];
      end
    end
  end

  // ---------------- stage 1 compute ----------------
  logic [XLEN-1:0]  simm, zimm, addr, npc4, s1_npc, s1_val;
  logic [4:0]       sh;
  logic             s1_wr, s1_halt;
  logic [REG_AW-1:0] s1_widx;
  mem_e             s1_mem;

  assign simm = {{16{s1_imm_q[15]}}, s1_imm_q[15:0]};
  assign zimm = {16'b0, s1_imm_q[15:0]};
  assign sh   = s1_imm_q[4:0];
  assign addr = rs + simm;
  assign npc4 = pc_q + 32'd4;

  always_comb begin
    logic [XLEN-1:0] btgt, jtgt;
    btgt    = npc4 + {simm[XLEN-3:0], 2'b00};
    jtgt    = {npc4[31:28], s1_imm_q, 2'b00};
    s1_wr   = 1'b0;
    s1_widx = s1_rd_i_q;
    s1_val  = '0;
    s1_npc  = npc4;
    s1_mem  = M_NONE;
    s1_halt = halt_q;
    if (halt_q) begin
      s1_npc = pc_q;
    end else begin
      case (func_e'(s1_func_q))
        F_ADD, F_ADDU: begin s1_wr = 1'b1; s1_val = rs + rt; end
        F_SUB:  begin s1_wr = 1'b1; s1_val = rs - rt; end
        F_AND:  begin s1_wr = 1'b1; s1_val = rs & rt; end
        F_OR:   begin s1_wr = 1'b1; s1_val = rs | rt; end
        F_XOR:  begin s1_wr = 1'b1; s1_val = rs ^ rt; end
        F_NOR:  begin s1_wr = 1'b1; s1_val = ~(rs | rt); end
        F_NAND: begin s1_wr = 1'b1; s1_val = ~(rs & rt); end
        F_SLT:  begin s1_wr = 1'b1; s1_val = {31'b0, $signed(rs) < $signed(rt)}; end
        F_SLL:  begin s1_wr = 1'b1; s1_val = rt << sh; end
        F_SRL:  begin s1_wr = 1'b1; s1_val = rt >> sh; end
        F_SRA:  begin s1_wr = 1'b1; s1_val = XLEN'($signed(rt) >>> sh); end
        F_JR:   s1_npc = rs;
        F_ADDI, F_ADDIU: begin
          s1_wr = 1'b1; s1_widx = s1_rt_i_q; s1_val = addr;
        end
        F_LW:   begin s1_wr = 1'b1; s1_widx = s1_rt_i_q; s1_mem = M_LW; end
        F_LH:   begin s1_wr = 1'b1; s1_widx = s1_rt_i_q; s1_mem = M_LH; end
        F_LHU:  begin s1_wr = 1'b1; s1_widx = s1_rt_i_q; s1_mem = M_LHU; end
        F_LB:   begin s1_wr = 1'b1; s1_widx = s1_rt_i_q; s1_mem = M_LB; end
        F_LBU:  begin s1_wr = 1'b1; s1_widx = s1_rt_i_q; s1_mem = M_LBU; end
        F_SW:   s1_mem = M_SW;
        F_SH, F_SB: s1_mem = M_SHB;
        F_LUI:  begin s1_wr = 1'b1; s1_widx = s1_rt_i_q; s1_val = {s1_imm_q[15:0], 16'b0}; end
        F_ANDI: begin s1_wr = 1'b1; s1_widx = s1_rt_i_q; s1_val = rs & zimm; end
        F_ORI:  begin s1_wr = 1'b1; s1_widx = s1_rt_i_q; s1_val = rs | zimm; end
        F_NORI: begin s1_wr = 1'b1; s1_widx = s1_rt_i_q; s1_val = ~(rs | zimm); end
        F_SLTI: begin
          s1_wr = 1'b1; s1_widx = s1_rt_i_q;
          s1_val = {31'b0, $signed(rs) < $signed(simm)};
        end
        F_BEQ:  if (rs == rt) s1_npc = btgt;
        F_BNE:  if (rs != rt) s1_npc = btgt;
        F_BGTZ: if (rs != '0 && !rs[31]) s1_npc = btgt;
        F_J:    s1_npc = jtgt;
        F_JAL:  begin
          s1_wr = 1'b1; s1_widx = REG_RA; s1_val = npc4; s1_npc = jtgt;
        end
        F_HALT: begin s1_halt = 1'b1; s1_npc = pc_q; end
        default: ;
      endcase
    end
    // drop writes to register zero
    if (s1_widx == REG_ZERO) s1_wr = 1'b0;
  end

  // data RAM: read issued from stage 1, written from stage 2
  always_ff @(posedge clk_i) begin
    if (dm_we) dm_mem[dm_wa] <= dm_wd;
    if (adv) dm_rd_q <= dm_mem[addr[DM_AW+1:2]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dm_vld_q  <= '0;
      dm_rvld_q <= 1'b0;
    end else begin
      if (dm_we) dm_vld_q[dm_wa] <= 1'b1;
      if (adv) dm_rvld_q <= dm_vld_q[addr[DM_AW+1:2]];
    end
  end

  // ---------------- stage 2 compute ----------------
  logic [XLEN-1:0] w, mask, ins;
  logic [4:0]      bsh, hsh;
  logic [7:0]      bval;
  logic [15:0]     hval;

  assign w    = (mw_v_q && mw_idx_q == s2_wi_q) ? mw_data_q :
                (dm_rvld_q ? dm_rd_q : '0);
  assign bsh  = {~s2_al_q, 3'b000};
  assign hsh  = s2_al_q[1] ? 5'd0 : 5'd16;
  assign bval = 8'(w >> bsh);
  assign hval = 16'(w >> hsh);

  always_comb begin
    if (s2_byte_q) begin
      mask = 32'h0000_00ff << bsh;
      ins  = {24'b0, s2_rt_q[7:0]} << bsh;
    end else begin
      mask = 32'h0000_ffff << hsh;
      ins  = {16'b0, s2_rt_q[15:0]} << hsh;
    end
    case (s2_mem_q)
      M_LW:    s2_wval = w;
      M_LH:    s2_wval = {{16{hval[15]}}, hval};
      M_LHU:   s2_wval = {16'b0, hval};
      M_LB:    s2_wval = {{24{bval[7]}}, bval};
      M_LBU:   s2_wval = {24'b0, bval};
      default: s2_wval = s2_val_q;
    endcase
  end

  assign dm_we = adv && s2_v_q && (s2_mem_q == M_SW || s2_mem_q == M_SHB);
  assign dm_wa = s2_wi_q;
  assign dm_wd = (s2_mem_q == M_SW) ? s2_rt_q : ((w & ~mask) | ins);

  // ---------------- pipeline registers ----------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_func_q <= req.func;
      s1_rs_i_q <= req.src_index;
      s1_rt_i_q <= req.tgt_index;
      s1_rd_i_q <= req.dst_index;
      s1_imm_q  <= req.immediate;
      s2_widx_q <= s1_widx;
      s2_val_q  <= s1_val;
      s2_rt_q   <= rt;
      s2_npc_q  <= s1_npc;
      s2_halt_q <= s1_halt;
      s2_byte_q <= (s1_func_q == F_SB);
      s2_al_q   <= addr[1:0];
      s2_wi_q   <= addr[DM_AW+1:2];
      wb_idx_q  <= s2_widx_q;
      wb_val_q  <= s2_wval;
      mw_idx_q  <= s2_wi_q;
      mw_data_q <= dm_wd;
      rsp.wrote_register <= s2_wr_q;
      rsp.written_index  <= s2_wr_q ? s2_widx_q : REG_ZERO;
      rsp.written_value  <= s2_wr_q ? s2_wval : '0;
      rsp.next_pc        <= s2_npc_q;
      rsp.halted         <= s2_halt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_pc_q <= '0;
      cfg_sp_q <= '0;
      pc_q     <= '0;
      halt_q   <= 1'b0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s2_wr_q  <= 1'b0;
      s2_mem_q <= M_NONE;
      wb_v_q   <= 1'b0;
      mw_v_q   <= 1'b0;
      o_v_q    <= 1'b0;
    end else begin
      if (adv) begin
        s1_v_q   <= req.valid;
        s2_v_q   <= s1_v_q;
        s2_wr_q  <= s1_v_q && s1_wr;
        s2_mem_q <= s1_v_q ? s1_mem : M_NONE;
        mw_v_q   <= dm_we;
        o_v_q    <= s2_v_q;
        if (s1_v_q) halt_q <= s1_halt;
      end
      if (cfg_we && paddr[2] == CFG_SP_INIT) wb_v_q <= 1'b0;
      else if (adv) wb_v_q <= s2_v_q && s2_wr_q;
      if (cfg_we && paddr[2] == CFG_START_PC) pc_q <= pwdata;
      else if (adv && s1_v_q) pc_q <= s1_npc;
      if (cfg_we) begin
        if (paddr[2] == CFG_START_PC) cfg_pc_q <= pwdata;
        else cfg_sp_q <= pwdata;
      end
    end
  end

  assign rsp.valid = o_v_q;

`ifndef ASSERT_OFF
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q) else $error("halt flag cleared");
  a_no_r0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> rf_wa != REG_ZERO) else $error("write to register zero");
  a_halted_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && halt_q) |-> (!s1_wr && s1_mem == M_NONE && s1_npc == pc_q))
    else $error("halted instruction has side effects");
  a_stall_holds_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv && !cfg_we) |=> $stable(pc_q)) else $error("pc moved during stall");
  a_store_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dm_we |-> !s2_wr_q) else $error("store also writes a register");
`endif

endmodule
